// ----- sv/integer_field_formatter_unit_defines.svh -----
// Assertion macros for the integer field formatter unit.
// Included by the top level; no other dependencies.
`ifndef INTEGER_FIELD_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define IFFU_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define IFFU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IFFU_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg)
`define IFFU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/iffu_pkg.sv -----
// Shared types and constants of the integer field formatter unit.
// No dependencies.
`default_nettype none
package iffu_pkg;
   localparam logic [1:0] FUNC_DEC  = 2'd0;
   localparam logic [1:0] FUNC_HEXL = 2'd1;
   localparam logic [1:0] FUNC_HEXU = 2'd2;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   localparam int DEC_DIGITS = 10;
   localparam int HEX_DIGITS = 8;
   localparam int MAX_WIDTH_DEF = 63;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;
   localparam int RECIP_SHIFT = 35;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_A_LO  = 8'h61;
   localparam logic [7:0] CH_A_UP  = 8'h41;

   typedef enum logic [1:0] {
      ORD_PAD_LEAD_DIG = 2'd0,
      ORD_LEAD_PAD_DIG = 2'd1,
      ORD_LEAD_DIG_PAD = 2'd2
   } order_type;

   typedef struct packed {
      logic [DEC_DIGITS-1:0][3:0] digits;
      logic [3:0]                 ndig;
      logic                       upper;
      logic [1:0]                 lead_len;
      logic [7:0]                 lead0;
      logic [7:0]                 lead1;
      logic [5:0]                 pad_len;
      logic [7:0]                 pad_char;
      order_type                  order;
   } desc_type;
endpackage
`default_nettype wire

// ----- sv/iffu_front.sv -----
// Front end: accepts input beats, classifies them and extracts decimal digits.
// Depends on iffu_pkg.
`default_nettype none
module iffu_front #(
   parameter int MAX_WIDTH = iffu_pkg::MAX_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_value,
   input  logic               req_left_justify,
   input  logic               req_zero_pad,
   input  logic               req_plus_sign,
   input  logic               req_space_sign,
   input  logic               req_alt_prefix,
   input  logic [5:0]         req_field_width,
   output logic               push,
   output iffu_pkg::desc_type desc,
   input  logic               full
);
   import iffu_pkg::*;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MUL  = 4'b0010,
      F_DIV  = 4'b0100,
      F_PUSH = 4'b1000
   } fstate_type;

   localparam logic [5:0] MAX_W = 6'(MAX_WIDTH);

   fstate_type  state_ff, state_in;
   logic [1:0]  func_ff, func_in;
   logic [31:0] value_ff, value_in;
   logic        left_ff, left_in, zpad_ff, zpad_in, plus_ff, plus_in;
   logic        spc_ff, spc_in, alt_ff, alt_in, neg_ff, neg_in;
   logic [5:0]  width_ff, width_in;
   logic [31:0] mag_ff, mag_in;
   logic [63:0] prod_ff, prod_in;
   logic [3:0]  digit_ff [DEC_DIGITS];
   logic [3:0]  cnt_ff, cnt_in;
   logic        dig_we;
   logic [31:0] quot, rem_full;
   logic [5:0]  text_len;
   logic        hex;

   assign req_ready = (state_ff == F_IDLE);
   assign quot      = 32'(prod_ff[63:RECIP_SHIFT]);
   assign rem_full  = mag_ff - ((quot << 3) + (quot << 1));

   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      value_in = value_ff;
      left_in  = left_ff;
      zpad_in  = zpad_ff;
      plus_in  = plus_ff;
      spc_in   = spc_ff;
      alt_in   = alt_ff;
      neg_in   = neg_ff;
      width_in = width_ff;
      mag_in   = mag_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      dig_we   = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               value_in = req_value;
               left_in  = req_left_justify;
               zpad_in  = req_zero_pad;
               plus_in  = req_plus_sign;
               spc_in   = req_space_sign;
               alt_in   = req_alt_prefix;
               width_in = (req_field_width > MAX_W) ? MAX_W : req_field_width;
               neg_in   = req_value[31];
               mag_in   = req_value[31] ? (32'd0 - req_value) : req_value;
               cnt_in   = 4'd0;
               if (req_func == FUNC_DEC) begin
                  state_in = F_MUL;
               end else if (req_func != FUNC_NONE) begin
                  state_in = F_PUSH;
               end
            end
         end
         F_MUL: begin
            prod_in  = 64'(mag_ff) * 64'(RECIP_TEN);
            state_in = F_DIV;
         end
         F_DIV: begin
            dig_we   = 1'b1;
            cnt_in   = cnt_ff + 4'd1;
            mag_in   = quot;
            state_in = (quot == 32'd0) ? F_PUSH : F_MUL;
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      func_ff  <= func_in;
      value_ff <= value_in;
      left_ff  <= left_in;
      zpad_ff  <= zpad_in;
      plus_ff  <= plus_in;
      spc_ff   <= spc_in;
      alt_ff   <= alt_in;
      neg_ff   <= neg_in;
      width_ff <= width_in;
      mag_ff   <= mag_in;
      prod_ff  <= prod_in;
      cnt_ff   <= cnt_in;
      if (dig_we) begin
         digit_ff[cnt_ff] <= rem_full[3:0];
      end
   end

   assign push = (state_ff == F_PUSH) && !full;
   assign hex  = (func_ff != FUNC_DEC);

   always_comb begin
      desc = '0;
      if (hex) begin
         for (int i = 0; i < HEX_DIGITS; i++) begin
            desc.digits[i] = value_ff[4*i +: 4];
         end
      end else begin
         for (int i = 0; i < DEC_DIGITS; i++) begin
            desc.digits[i] = digit_ff[i];
         end
      end
      desc.ndig  = hex ? 4'(HEX_DIGITS) : cnt_ff;
      desc.upper = (func_ff == FUNC_HEXU);
      desc.lead0 = CH_ZERO;
      desc.lead1 = desc.upper ? CH_X_UP : CH_X_LO;
      if (hex) begin
         desc.lead_len = alt_ff ? 2'd2 : 2'd0;
         desc.pad_char = zpad_ff ? CH_ZERO : CH_SPACE;
      end else begin
         priority if (neg_ff) begin
            desc.lead0 = CH_MINUS;
         end else if (plus_ff) begin
            desc.lead0 = CH_PLUS;
         end else begin
            desc.lead0 = CH_SPACE;
         end
         desc.lead_len = (neg_ff || plus_ff || spc_ff) ? 2'd1 : 2'd0;
         desc.pad_char = (zpad_ff && !left_ff) ? CH_ZERO : CH_SPACE;
      end
      priority if (left_ff) begin
         desc.order = ORD_LEAD_DIG_PAD;
      end else if (!hex && zpad_ff) begin
         desc.order = ORD_LEAD_PAD_DIG;
      end else begin
         desc.order = ORD_PAD_LEAD_DIG;
      end
      text_len     = 6'(desc.lead_len) + 6'(desc.ndig);
      desc.pad_len = (width_ff > text_len) ? (width_ff - text_len) : 6'd0;
   end
endmodule
`default_nettype wire

// ----- sv/iffu_queue.sv -----
// Short descriptor queue between the front end and the character emitter.
// Depends on iffu_pkg.
`default_nettype none
module iffu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  iffu_pkg::desc_type push_desc,
   output logic               full,
   input  logic               pop,
   output iffu_pkg::desc_type pop_desc,
   output logic               empty
);
   import iffu_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   desc_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end
endmodule
`default_nettype wire

// ----- sv/iffu_emitter.sv -----
// Back end: walks one descriptor and sends one character beat per cycle while rsp_ready is high.
// Depends on iffu_pkg.
`default_nettype none
module iffu_emitter (
   input  logic               clock,
   input  logic               reset,
   input  iffu_pkg::desc_type desc,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_char_code,
   output logic               rsp_last
);
   import iffu_pkg::*;

   typedef enum logic [1:0] {
      SEG_LEAD = 2'd0,
      SEG_PAD  = 2'd1,
      SEG_DIG  = 2'd2
   } seg_kind_type;

   function automatic seg_kind_type seg_kind(input order_type ord, input logic [1:0] idx);
      seg_kind_type k;
      k = SEG_DIG;
      unique case (ord)
         ORD_PAD_LEAD_DIG: k = (idx == 2'd0) ? SEG_PAD : (idx == 2'd1) ? SEG_LEAD : SEG_DIG;
         ORD_LEAD_PAD_DIG: k = (idx == 2'd0) ? SEG_LEAD : (idx == 2'd1) ? SEG_PAD : SEG_DIG;
         ORD_LEAD_DIG_PAD: k = (idx == 2'd0) ? SEG_LEAD : (idx == 2'd1) ? SEG_DIG : SEG_PAD;
         default:          k = SEG_DIG;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] seg_len(input desc_type d, input seg_kind_type k);
      logic [5:0] len;
      unique case (k)
         SEG_LEAD: len = 6'(d.lead_len);
         SEG_PAD:  len = d.pad_len;
         SEG_DIG:  len = 6'(d.ndig);
         default:  len = 6'd0;
      endcase
      return len;
   endfunction

   function automatic logic [1:0] first_seg(input desc_type d, input logic [1:0] start);
      logic [1:0] sel;
      logic       found;
      sel   = 2'd2;
      found = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (!found && (2'(i) >= start) && (seg_len(d, seg_kind(d.order, 2'(i))) != 6'd0)) begin
            sel   = 2'(i);
            found = 1'b1;
         end
      end
      return sel;
   endfunction

   logic         busy_ff, busy_in;
   desc_type     desc_ff, desc_in;
   logic [1:0]   seg_ff, seg_in;
   logic [5:0]   pos_ff, pos_in;
   logic [5:0]   rem_ff, rem_in;
   logic         valid_ff, valid_in;
   logic [7:0]   char_ff, char_in;
   logic         last_ff, last_in;
   logic         step;
   seg_kind_type kind;
   logic [3:0]   dig_idx;
   logic [3:0]   dig;
   logic [7:0]   cur_char;

   assign pop  = !busy_ff && !empty;
   assign step = busy_ff && (!valid_ff || rsp_ready);
   assign kind = seg_kind(desc_ff.order, seg_ff);

   assign dig_idx = desc_ff.ndig - 4'd1 - pos_ff[3:0];
   assign dig     = desc_ff.digits[dig_idx];

   always_comb begin
      unique case (kind)
         SEG_LEAD: cur_char = pos_ff[0] ? desc_ff.lead1 : desc_ff.lead0;
         SEG_PAD:  cur_char = desc_ff.pad_char;
         SEG_DIG: begin
            if (dig < 4'd10) begin
               cur_char = CH_ZERO + 8'(dig);
            end else begin
               cur_char = (desc_ff.upper ? CH_A_UP : CH_A_LO) + 8'(dig) - 8'd10;
            end
         end
         default:  cur_char = CH_SPACE;
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      desc_in  = desc_ff;
      seg_in   = seg_ff;
      pos_in   = pos_ff;
      rem_in   = rem_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         busy_in = 1'b1;
         desc_in = desc;
         seg_in  = first_seg(desc, 2'd0);
         pos_in  = 6'd0;
         rem_in  = 6'(7'(desc.lead_len) + 7'(desc.pad_len) + 7'(desc.ndig));
      end
      if (step) begin
         valid_in = 1'b1;
         char_in  = cur_char;
         last_in  = (rem_ff == 6'd1);
         rem_in   = rem_ff - 6'd1;
         if (rem_ff == 6'd1) begin
            busy_in = 1'b0;
         end else if ((pos_ff + 6'd1) < seg_len(desc_ff, kind)) begin
            pos_in = pos_ff + 6'd1;
         end else begin
            seg_in = first_seg(desc_ff, seg_ff + 2'd1);
            pos_in = 6'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      desc_ff <= desc_in;
      seg_ff  <= seg_in;
      pos_ff  <= pos_in;
      rem_ff  <= rem_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;
endmodule
`default_nettype wire

// ----- sv/integer_field_formatter_unit.sv -----
// Top level of the integer field formatter unit: front end, queue, emitter.
// Depends on iffu_pkg, iffu_front, iffu_queue, iffu_emitter and the defines header.
//
// The req_ channel takes one value with its conversion code, flags and minimum
// width per beat. The rsp_ channel returns the formatted text, one ASCII
// character per beat, with rsp_last on the final character of each value.
// Conversion code 3 is accepted and produces no characters.
// The front end holds one value at a time: a hex value goes straight to the
// push state after acceptance, a decimal value first passes once per digit
// through the reciprocal multiply and the remainder step, up to 10 digits;
// a push waits while the queue is full. Two descriptors wait in the queue, so
// the front end takes new values while the emitter is still sending earlier ones.
// The emitter loads a descriptor and then sends one character per cycle while
// rsp_ready is high, up to 63 per value; it takes the next descriptor only
// after it has produced the last character of the current one.
// A synchronous reset empties the queue and drops any value in flight. While
// rsp_ready is low the output beat holds and the front end keeps filling the
// queue until it is full.
`default_nettype none
`include "integer_field_formatter_unit_defines.svh"
module integer_field_formatter_unit #(
   parameter int MAX_WIDTH = iffu_pkg::MAX_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_value,
   input  logic               req_left_justify,
   input  logic               req_zero_pad,
   input  logic               req_plus_sign,
   input  logic               req_space_sign,
   input  logic               req_alt_prefix,
   input  logic [5:0]         req_field_width,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_char_code,
   output logic               rsp_last
);
   import iffu_pkg::*;

   logic     q_push, q_pop, q_full, q_empty;
   logic     fmt_take;
   desc_type push_desc, pop_desc;

   assign fmt_take = req_valid && req_ready && (req_func != FUNC_NONE);

   iffu_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_value        (req_value),
      .req_left_justify (req_left_justify),
      .req_zero_pad     (req_zero_pad),
      .req_plus_sign    (req_plus_sign),
      .req_space_sign   (req_space_sign),
      .req_alt_prefix   (req_alt_prefix),
      .req_field_width  (req_field_width),
      .push             (q_push),
      .desc             (push_desc),
      .full             (q_full)
   );

   iffu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_desc  (pop_desc),
      .empty     (q_empty)
   );

   iffu_emitter u_emitter (
      .clock         (clock),
      .reset         (reset),
      .desc          (pop_desc),
      .empty         (q_empty),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   `IFFU_ASSERT_HOLDS(a_push_not_full, clock, reset, q_push, !q_full, "push into full queue")
   `IFFU_ASSERT_HOLDS(a_pop_not_empty, clock, reset, q_pop, !q_empty, "pop from empty queue")
   `IFFU_ASSERT_NEXT(a_front_busy, clock, reset, fmt_take, !req_ready, "front end idle after accept")
endmodule
`default_nettype wire
